// ===== rtl/tfd_pkg.sv =====
// Shared types and constants for the tilt fall-direction detector.
`default_nettype none

package tfd_pkg;

    // Field widths fixed by the sample and register formats.
    localparam int ANGLE_W  = 16;
    localparam int LIMIT_W  = 15;
    localparam int SETTLE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_BAND_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_BAND_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT   = 2'd3;

    // Register values after reset.
    localparam logic [LIMIT_W-1:0]  TILT_LIMIT_RST     = 15'd3200;
    localparam logic [LIMIT_W-1:0]  FALL_BAND_LOW_RST  = 15'd7680;
    localparam logic [LIMIT_W-1:0]  FALL_BAND_HIGH_RST = 15'd15360;
    localparam logic [SETTLE_W-1:0] SETTLE_COUNT_RST   = 8'd10;

    // Posture codes as seen on the result port.
    typedef enum logic [2:0] {
        POS_STABLE   = 3'd0,
        POS_UNSTABLE = 3'd1,
        POS_FRONT    = 3'd2,
        POS_BACK     = 3'd3,
        POS_LEFT     = 3'd4,
        POS_RIGHT    = 3'd5
    } posture_t;

    // Classification of one sample against the tilt limit and fall bands.
    typedef struct packed {
        logic tilted;
        logic front;
        logic back;
        logic left;
        logic right;
    } tilt_class_t;

endpackage

`default_nettype wire

// ===== rtl/tfd_classify.sv =====
// Compares one registered sample against the tilt limit and the fall bands.
`default_nettype none

module tfd_classify
    import tfd_pkg::*;
(
    input  wire logic signed [ANGLE_W-1:0] pitch_deg,
    input  wire logic signed [ANGLE_W-1:0] roll_deg,
    input  wire logic [LIMIT_W-1:0]        tilt_limit,
    input  wire logic [LIMIT_W-1:0]        fall_band_low,
    input  wire logic [LIMIT_W-1:0]        fall_band_high,
    output tilt_class_t                    cls
);

    localparam int EXT_W = ANGLE_W + 1;

    logic signed [EXT_W-1:0] pitch_x;
    logic signed [EXT_W-1:0] roll_x;
    logic signed [EXT_W-1:0] lim_x;
    logic signed [EXT_W-1:0] lo_x;
    logic signed [EXT_W-1:0] hi_x;
    logic signed [EXT_W-1:0] lim_neg;
    logic signed [EXT_W-1:0] lo_neg;
    logic signed [EXT_W-1:0] hi_neg;

    // One extra bit keeps the most negative angle and the negated limits exact.
    always_comb
    begin
        pitch_x = {pitch_deg[ANGLE_W-1], pitch_deg};
        roll_x  = {roll_deg[ANGLE_W-1], roll_deg};
        lim_x   = signed'({{(EXT_W-LIMIT_W){1'b0}}, tilt_limit});
        lo_x    = signed'({{(EXT_W-LIMIT_W){1'b0}}, fall_band_low});
        hi_x    = signed'({{(EXT_W-LIMIT_W){1'b0}}, fall_band_high});
        lim_neg = -lim_x;
        lo_neg  = -lo_x;
        hi_neg  = -hi_x;
    end

    // Magnitude tests are split into a positive and a negative compare.
    always_comb
    begin
        cls.tilted = (pitch_x > lim_x) || (pitch_x < lim_neg)
                  || (roll_x > lim_x) || (roll_x < lim_neg);
        cls.front  = (pitch_x > lo_x) && (pitch_x < hi_x);
        cls.back   = (pitch_x < lo_neg) && (pitch_x > hi_neg);
        cls.right  = (roll_x > lo_x) && (roll_x < hi_x);
        cls.left   = (roll_x < lo_neg) && (roll_x > hi_neg);
    end

endmodule

`default_nettype wire

// ===== rtl/tfd_runs.sv =====
// Run counters and posture register, updated once per sample.
`default_nettype none

module tfd_runs
    import tfd_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                clear,
    input  wire tilt_class_t         cls,
    input  wire logic [SETTLE_W-1:0] settle_count,
    output posture_t                 posture
);

    localparam int CMP_W = COUNT_WIDTH + SETTLE_W;

    logic [COUNT_WIDTH-1:0] front_run_reg, front_run_next;
    logic [COUNT_WIDTH-1:0] back_run_reg,  back_run_next;
    logic [COUNT_WIDTH-1:0] left_run_reg,  left_run_next;
    logic [COUNT_WIDTH-1:0] right_run_reg, right_run_next;
    logic [COUNT_WIDTH-1:0] calm_run_reg,  calm_run_next;
    posture_t               posture_reg,   posture_next;
    logic [CMP_W-1:0]       settle_x;

    // Saturating increment of a run counter, starting from zero on clear.
    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] run,
                                                    input logic cl);
        logic [COUNT_WIDTH-1:0] base;
        base = cl ? '0 : run;
        return (base == '1) ? base : base + 1'b1;
    endfunction

    function automatic logic over(input logic [COUNT_WIDTH-1:0] run,
                                  input logic [CMP_W-1:0] lim);
        logic [CMP_W-1:0] run_x;
        run_x = {{SETTLE_W{1'b0}}, run};
        return run_x > lim;
    endfunction

    // Next counter values and posture for the sample in flight.
    always_comb
    begin
        settle_x = {{COUNT_WIDTH{1'b0}}, settle_count};
        if (cls.tilted)
        begin
            calm_run_next  = '0;
            front_run_next = cls.front ? bump(front_run_reg, clear) : '0;
            back_run_next  = cls.back  ? bump(back_run_reg, clear)  : '0;
            left_run_next  = cls.left  ? bump(left_run_reg, clear)  : '0;
            right_run_next = cls.right ? bump(right_run_reg, clear) : '0;
        end
        else
        begin
            calm_run_next  = bump(calm_run_reg, clear);
            front_run_next = '0;
            back_run_next  = '0;
            left_run_next  = '0;
            right_run_next = '0;
        end

        posture_next = posture_reg;
        if (cls.tilted && (cls.front || cls.back || cls.left || cls.right))
        begin
            posture_next = POS_UNSTABLE;
        end
        if (over(front_run_next, settle_x))
        begin
            posture_next = POS_FRONT;
        end
        else if (over(back_run_next, settle_x))
        begin
            posture_next = POS_BACK;
        end
        else if (over(left_run_next, settle_x))
        begin
            posture_next = POS_LEFT;
        end
        else if (over(right_run_next, settle_x))
        begin
            posture_next = POS_RIGHT;
        end
        else if (over(calm_run_next, settle_x))
        begin
            posture_next = POS_STABLE;
        end
    end

    // State registers move only when a sample is retired.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_run_reg <= '0;
            back_run_reg  <= '0;
            left_run_reg  <= '0;
            right_run_reg <= '0;
            calm_run_reg  <= '0;
            posture_reg   <= POS_STABLE;
        end
        else if (step)
        begin
            front_run_reg <= front_run_next;
            back_run_reg  <= back_run_next;
            left_run_reg  <= left_run_next;
            right_run_reg <= right_run_next;
            calm_run_reg  <= calm_run_next;
            posture_reg   <= posture_next;
        end
    end

    assign posture = posture_reg;

    // A calm run and a direction run never count at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (calm_run_reg != '0) |-> ((front_run_reg | back_run_reg
                                   | left_run_reg | right_run_reg) == '0))
        else $error("calm run active together with a direction run");

endmodule

`default_nettype wire

// ===== rtl/tilt_fall_direction_detector.sv =====
// Top level of the tilt fall-direction detector: config registers and pipeline control.
//
// The block takes one pitch/roll beat per clock cycle unless the result side stalls. An
// accepted beat is held in an input register while it is compared against the tilt
// limit and the fall bands, then retired into the run counters and the posture register,
// which also serves as the result register: the posture beat is offered once the held
// beat has retired, and with the result side always ready a new sample is taken every
// cycle. The rate is set by the single compare-and-count pass between the input register
// and the counters. Configuration writes take effect at once and are meant to be made
// while no beat is in flight.
`default_nettype none

module tilt_fall_direction_detector
    import tfd_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire logic signed [ANGLE_W-1:0] pitch_deg,
    input  wire logic signed [ANGLE_W-1:0] roll_deg,
    input  wire logic                   clear_runs,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic [2:0]                  posture
);

    logic [LIMIT_W-1:0]  tilt_limit_reg;
    logic [LIMIT_W-1:0]  fall_band_low_reg;
    logic [LIMIT_W-1:0]  fall_band_high_reg;
    logic [SETTLE_W-1:0] settle_count_reg;

    logic                       hold_valid_reg;
    logic signed [ANGLE_W-1:0]  pitch_reg;
    logic signed [ANGLE_W-1:0]  roll_reg;
    logic                       clear_reg;
    logic                       result_valid_reg;
    logic                       advance;
    tilt_class_t                cls;
    posture_t                   posture_q;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_limit_reg     <= TILT_LIMIT_RST;
            fall_band_low_reg  <= FALL_BAND_LOW_RST;
            fall_band_high_reg <= FALL_BAND_HIGH_RST;
            settle_count_reg   <= SETTLE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TILT_LIMIT:     tilt_limit_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_FALL_BAND_LOW:  fall_band_low_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_FALL_BAND_HIGH: fall_band_high_reg <= cfg_data[LIMIT_W-1:0];
                CFG_SETTLE_COUNT:   settle_count_reg   <= cfg_data[SETTLE_W-1:0];
                default:            ;
            endcase
        end
    end

    // The held beat retires when the result slot is empty or being drained.
    assign advance      = hold_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !hold_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            hold_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            pitch_reg <= pitch_deg;
            roll_reg  <= roll_deg;
            clear_reg <= clear_runs;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    tfd_classify u_classify (
        .pitch_deg      (pitch_reg),
        .roll_deg       (roll_reg),
        .tilt_limit     (tilt_limit_reg),
        .fall_band_low  (fall_band_low_reg),
        .fall_band_high (fall_band_high_reg),
        .cls            (cls)
    );

    tfd_runs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_runs (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .clear        (clear_reg),
        .cls          (cls),
        .settle_count (settle_count_reg),
        .posture      (posture_q)
    );

    assign result_valid = result_valid_reg;
    assign posture      = posture_q;

    // The posture only changes when a beat retires.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(posture))
        else $error("posture changed without a retiring beat");

    // A held sample is never dropped while the result side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |=> hold_valid_reg)
        else $error("held sample lost while stalled");

    // A retired beat always leaves a result on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("retired beat produced no result");

endmodule

`default_nettype wire

// ===== tb/tb_tilt_fall_direction_detector.sv =====
// Self-checking testbench for the tilt fall-direction detector: directed, saturation and random runs.

module tb_tilt_fall_direction_detector;
    import tfd_pkg::*;

    localparam int COUNT_W      = 8;
    localparam int RUN_TOP      = (1 << COUNT_W) - 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Classes of angle used to shape samples.
    typedef enum int {
        ANG_CALM,
        ANG_POS_BAND,
        ANG_NEG_BAND,
        ANG_BEYOND,
        ANG_ANY
    } angle_kind_t;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_ready;
    logic signed [ANGLE_W-1:0]     pitch_deg    = '0;
    logic signed [ANGLE_W-1:0]     roll_deg     = '0;
    logic                          clear_runs   = 1'b0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic [2:0]                    posture;

    // Shadow copy of the configuration registers.
    logic [LIMIT_W-1:0]  tilt_lim_cfg  = TILT_LIMIT_RST;
    logic [LIMIT_W-1:0]  band_lo_cfg   = FALL_BAND_LOW_RST;
    logic [LIMIT_W-1:0]  band_hi_cfg   = FALL_BAND_HIGH_RST;
    logic [SETTLE_W-1:0] settle_cfg    = SETTLE_COUNT_RST;

    // Shadow copy of the run counters and the posture register.
    logic [COUNT_W-1:0]  front_cnt = '0;
    logic [COUNT_W-1:0]  back_cnt  = '0;
    logic [COUNT_W-1:0]  left_cnt  = '0;
    logic [COUNT_W-1:0]  right_cnt = '0;
    logic [COUNT_W-1:0]  calm_cnt  = '0;
    posture_t            posture_now = POS_STABLE;

    posture_t            expected_posture[$];
    posture_t            want_posture;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    int                  send_gap       = 0;
    int                  ready_hold     = 0;
    logic                quiet_link     = 1'b0;

    tilt_fall_direction_detector #(.COUNT_WIDTH(COUNT_W)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .pitch_deg    (pitch_deg),
        .roll_deg     (roll_deg),
        .clear_runs   (clear_runs),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .posture      (posture)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] MISMATCH: %s", cycle_count, what);
    endtask

    // Idle cycles drawn for one beat on either side.
    function automatic int draw_wait();
        return quiet_link ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [COUNT_W-1:0] bump_run(input logic [COUNT_W-1:0] c);
        return (c == RUN_TOP) ? c : c + 1'b1;
    endfunction

    function automatic int magnitude(input int a);
        return (a < 0) ? -a : a;
    endfunction

    // Advance the shadow counters by one sample and return the posture it yields.
    function automatic posture_t next_posture(input int p, input int r, input logic clr);
        int lo;
        int hi;
        int lim;
        lo  = band_lo_cfg;
        hi  = band_hi_cfg;
        lim = tilt_lim_cfg;
        if (clr)
        begin
            front_cnt = '0;
            back_cnt  = '0;
            left_cnt  = '0;
            right_cnt = '0;
            calm_cnt  = '0;
        end
        if (magnitude(p) > lim || magnitude(r) > lim)
        begin
            calm_cnt = '0;
            if (p > lo && p < hi)
            begin
                front_cnt   = bump_run(front_cnt);
                posture_now = POS_UNSTABLE;
            end
            else
                front_cnt = '0;
            if (p < -lo && p > -hi)
            begin
                back_cnt    = bump_run(back_cnt);
                posture_now = POS_UNSTABLE;
            end
            else
                back_cnt = '0;
            if (r > lo && r < hi)
            begin
                right_cnt   = bump_run(right_cnt);
                posture_now = POS_UNSTABLE;
            end
            else
                right_cnt = '0;
            if (r < -lo && r > -hi)
            begin
                left_cnt    = bump_run(left_cnt);
                posture_now = POS_UNSTABLE;
            end
            else
                left_cnt = '0;
        end
        else
        begin
            calm_cnt  = bump_run(calm_cnt);
            front_cnt = '0;
            back_cnt  = '0;
            left_cnt  = '0;
            right_cnt = '0;
        end
        // Settled counters decide the posture in fixed priority.
        if (front_cnt > settle_cfg)
            posture_now = POS_FRONT;
        else if (back_cnt > settle_cfg)
            posture_now = POS_BACK;
        else if (left_cnt > settle_cfg)
            posture_now = POS_LEFT;
        else if (right_cnt > settle_cfg)
            posture_now = POS_RIGHT;
        else if (calm_cnt > settle_cfg)
            posture_now = POS_STABLE;
        return posture_now;
    endfunction

    // Offer one sample beat, wait for it to be taken and record its posture.
    task automatic send_sample(input logic signed [ANGLE_W-1:0] p,
                               input logic signed [ANGLE_W-1:0] r,
                               input logic clr);
        repeat (send_gap) @(posedge clk);
        sample_valid <= 1'b1;
        pitch_deg    <= p;
        roll_deg     <= r;
        clear_runs   <= clr;
        do
            @(posedge clk);
        while (!sample_ready);
        expected_posture.push_back(next_posture(p, r, clr));
        // Valid stays up only when the next beat follows at once.
        send_gap = draw_wait();
        if (send_gap != 0)
            sample_valid <= 1'b0;
    endtask

    // Stop offering samples and wait until every posture beat has come back.
    task automatic drain_samples();
        if (send_gap == 0)
            sample_valid <= 1'b0;
        @(posedge clk);
        while (expected_posture.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_TILT_LIMIT:     tilt_lim_cfg = data;
            CFG_FALL_BAND_LOW:  band_lo_cfg  = data;
            CFG_FALL_BAND_HIGH: band_hi_cfg  = data;
            CFG_SETTLE_COUNT:   settle_cfg   = data[SETTLE_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] lim,
                                input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi,
                                input logic [CFG_DATA_W-1:0] settle);
        write_reg(CFG_TILT_LIMIT, lim);
        write_reg(CFG_FALL_BAND_LOW, lo);
        write_reg(CFG_FALL_BAND_HIGH, hi);
        write_reg(CFG_SETTLE_COUNT, settle);
    endtask

    // Draw an angle of the given class under the current thresholds.
    function automatic logic signed [ANGLE_W-1:0] pick_angle(input angle_kind_t kind);
        int lo;
        int hi;
        int lim;
        int a;
        lo  = band_lo_cfg;
        hi  = band_hi_cfg;
        lim = tilt_lim_cfg;
        case (kind)
            ANG_CALM:
                a = $urandom_range(0, lim);
            ANG_POS_BAND, ANG_NEG_BAND:
                a = (hi - lo >= 2) ? $urandom_range(lo + 1, hi - 1) : $urandom_range(0, 32767);
            ANG_BEYOND:
                a = $urandom_range((hi > lim) ? hi : lim, 32767);
            default:
                return ANGLE_W'($urandom_range(0, 65535));
        endcase
        if (kind == ANG_NEG_BAND || (kind != ANG_POS_BAND && $urandom_range(0, 1) == 1))
            a = -a;
        return a[ANGLE_W-1:0];
    endfunction

    function automatic angle_kind_t pick_kind();
        return angle_kind_t'($urandom_range(0, 4));
    endfunction

    // Runs of samples that hold one direction, with noise and occasional clears.
    task automatic run_sequences(input int total);
        int sent;
        int span;
        angle_kind_t pk;
        angle_kind_t rk;
        sent = 0;
        while (sent < total)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pk = ANG_CALM;
                rk = ANG_CALM;
            end
            else
            begin
                pk = pick_kind();
                rk = pick_kind();
            end
            span = $urandom_range(1, (settle_cfg > 30) ? 40 : settle_cfg + 6);
            repeat (span)
            begin
                send_sample(pick_angle(($urandom_range(0, 11) == 0) ? ANG_ANY : pk),
                            pick_angle(($urandom_range(0, 11) == 0) ? ANG_ANY : rk),
                            $urandom_range(0, 29) == 0);
                sent++;
            end
        end
    endtask

    // Reset thresholds: band edges, angle extremes and the clear flag.
    task automatic test_band_edges();
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sd7680, 16'sd0, 1'b0);
        send_sample(16'sd7681, 16'sd0, 1'b0);
        send_sample(16'sd15359, 16'sd0, 1'b0);
        send_sample(16'sd15360, 16'sd0, 1'b0);
        send_sample(-16'sd7681, 16'sd0, 1'b0);
        send_sample(-16'sd15359, 16'sd0, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, 1'b0);
        send_sample(-16'sd3200, 16'sd3200, 1'b0);
        send_sample(16'sd0, 16'sd3201, 1'b0);
        send_sample(16'sd0, 16'sd9000, 1'b0);
        send_sample(16'sd0, -16'sd9000, 1'b0);
        send_sample(16'sd23040, -16'sd23040, 1'b0);
        send_sample(16'sd8000, 16'sd8000, 1'b1);
        send_sample(16'sh5555, 16'shAAAA, 1'b0);
        drain_samples();
    endtask

    // With a settle count of zero one beat sets each posture code other than unstable.
    task automatic test_posture_codes();
        apply_config(15'd3200, 15'd7680, 15'd15360, 15'd0);
        send_sample(16'sd10000, 16'sd0, 1'b0);
        send_sample(-16'sd10000, 16'sd0, 1'b0);
        send_sample(16'sd0, -16'sd10000, 1'b0);
        send_sample(16'sd0, 16'sd10000, 1'b0);
        send_sample(16'sd10000, -16'sd10000, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd20000, 16'sd0, 1'b0);
        drain_samples();
    endtask

    // Front saturates while right keeps counting; a wrap would let right win.
    // Then a settle count at the counter maximum can never be exceeded.
    task automatic test_counter_saturation();
        apply_config(15'd3200, 15'd7680, 15'd15360, 15'd254);
        quiet_link = 1'b1;
        repeat (100) send_sample(16'sd10000, 16'sd0, 1'b0);
        repeat (262) send_sample(16'sd10000, 16'sd10000, 1'b0);
        quiet_link = 1'b0;
        drain_samples();
        apply_config(15'd3200, 15'd7680, 15'd15360, 15'h7FFF);
        repeat (20) send_sample(16'sd0, 16'sd0, 1'b0);
        repeat (20) send_sample(-16'sd10000, 16'sd0, 1'b0);
        drain_samples();
    endtask

    // Limits at both ends, the most negative angle and empty bands.
    task automatic test_threshold_extremes();
        apply_config(15'd0, 15'd0, 15'h7FFF, 15'd1);
        send_sample(16'sd0, 16'sd0, 1'b0);
        repeat (2) send_sample(16'sd1, 16'sd0, 1'b0);
        repeat (2) send_sample(-16'sd1, 16'sd0, 1'b0);
        repeat (2) send_sample(16'sd0, 16'sd1, 1'b0);
        repeat (2) send_sample(16'sd0, -16'sd1, 1'b0);
        send_sample(-16'sd32768, 16'sd0, 1'b0);
        send_sample(16'sd32767, 16'sd0, 1'b0);
        send_sample(16'sd0, -16'sd32768, 1'b0);
        repeat (10) send_sample(pick_angle(ANG_ANY), pick_angle(ANG_ANY), 1'b0);
        drain_samples();

        apply_config(15'h7FFF, 15'd100, 15'h7FFF, 15'd0);
        send_sample(-16'sd32768, -16'sd32768, 1'b0);
        send_sample(-16'sd32768, 16'sd5000, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 1'b0);
        send_sample(16'sd0, -16'sd32768, 1'b0);
        drain_samples();

        // Band edges equal, then crossed: no angle falls inside.
        apply_config(15'd1000, 15'd9000, 15'd9000, 15'd0);
        send_sample(16'sd9000, 16'sd9000, 1'b0);
        send_sample(16'sd9001, -16'sd9001, 1'b0);
        send_sample(16'sd8999, -16'sd8999, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0);
        drain_samples();
        apply_config(15'd1000, 15'd12000, 15'd8000, 15'd0);
        send_sample(16'sd10000, 16'sd10000, 1'b0);
        send_sample(-16'sd10000, -16'sd10000, 1'b0);
        repeat (10) send_sample(pick_angle(ANG_ANY), pick_angle(ANG_BEYOND), 1'b0);
        drain_samples();
    endtask

    // Random thresholds per phase, each followed by random runs.
    task automatic test_random_runs();
        int lo;
        int hi;
        int lim;
        logic [CFG_DATA_W-1:0] settle_word;
        for (int phase = 0; phase < 6; phase++)
        begin
            lo = $urandom_range(0, 15000);
            case ($urandom_range(0, 7))
                0:       hi = lo;
                1:       hi = $urandom_range(0, lo);
                default: hi = lo + $urandom_range(2, 8000);
            endcase
            lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 23040)
                                              : $urandom_range(0, lo);
            settle_word = ($urandom_range(0, 7) == 0)
                        ? CFG_DATA_W'($urandom_range(200, 255))
                        : CFG_DATA_W'($urandom_range(0, 12));
            if ($urandom_range(0, 3) == 0)
                settle_word[CFG_DATA_W-1:SETTLE_W] =
                    (CFG_DATA_W-SETTLE_W)'($urandom_range(0, 127));
            apply_config(CFG_DATA_W'(lim), CFG_DATA_W'(lo), CFG_DATA_W'(hi), settle_word);
            quiet_link = ($urandom_range(0, 3) == 0);
            run_sequences(160);
            drain_samples();
        end
        quiet_link = 1'b0;
    endtask

    // Check each posture beat against the oldest prediction and pace result_ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_posture.size() == 0)
                    report_mismatch($sformatf("posture beat %0d with nothing expected",
                                              posture));
                else
                begin
                    want_posture = expected_posture.pop_front();
                    if (posture !== want_posture)
                        report_mismatch($sformatf("posture got %0d, expected %0d (%s)",
                                                  posture, want_posture,
                                                  want_posture.name()));
                end
                ready_hold = draw_wait();
                if (ready_hold != 0)
                    result_ready <= 1'b0;
            end
            else if (!result_ready)
            begin
                if (ready_hold > 1)
                    ready_hold--;
                else
                    result_ready <= 1'b1;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_band_edges();
        test_posture_codes();
        test_counter_saturation();
        test_threshold_extremes();
        test_random_runs();
        drain_samples();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
